>>> src/sxe_pkg.sv
// sxe_pkg: shared types, codes and helpers for the stack expression evaluator.
// Depends on nothing; used by sxe_alu, stack_expression_evaluator, sxe_checker and testbench.

package sxe_pkg;

  localparam int STACK_DEPTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int DATA_W          = 32;
  localparam int PADDR_W         = 3;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;

  // register index (paddr[2])
  localparam logic [0:0] REG_MODE = 1'b0;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_UNDER = 2'd1,
    STS_DIV0  = 2'd2,
    STS_OVF   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       is_last;
  } char_word_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    status_t                  status;
  } res_word_t;

  typedef struct packed {
    logic start;
    op_t  op;
  } alu_req_t;

  function automatic logic is_op_char(input logic [7:0] c);
    return (c == CH_PLUS) || (c == CH_MINUS) || (c == CH_STAR) || (c == CH_SLASH);
  endfunction

  function automatic op_t op_decode(input logic [7:0] c);
    op_t o;
    case (c)
      CH_PLUS:  o = OP_ADD;
      CH_MINUS: o = OP_SUB;
      CH_STAR:  o = OP_MUL;
      default:  o = OP_DIV;
    endcase
    return o;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
    logic signed [DATA_W-1:0] r;
    if (x > 64'sh0000_0000_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (x < -64'sh0000_0000_8000_0000) begin
      r = 32'sh8000_0000;
    end else begin
      r = x[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> src/stack_expression_evaluator.sv
// stack_expression_evaluator: top level; RPN sequencer around the operand stack RAM.
// Depends on sxe_pkg, sxe_ram, sxe_alu.
//
//   channel   handshake                    payload
//   char      char_valid / char_stall      char_word (char_code, is_last)
//   res       res_valid  / res_stall       res_word  (value, status)
//   cfg       psel penable pwrite pready   paddr, pwdata, prdata
//
// Digits and ignored characters are taken in ST_IDLE; + and - pass through ST_RD1, ST_RD2, ST_EXEC,
// * also through the ALU's A_MUL state, / waits on the one-bit-per-cycle divider (Q16.16 by default).
// A word marked is_last passes through ST_EMIT to load the result register.
// Stack reads go through the single RAM read port, one operand per cycle.
// rst is synchronous; the stack RAM is not cleared, only the count.
// A waiting result does not block input until the next result must be loaded.

module stack_expression_evaluator #(
  parameter int STACK_DEPTH = sxe_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = sxe_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sxe_pkg::PADDR_W-1:0]         paddr,
  input  logic [sxe_pkg::DATA_W-1:0]          pwdata,
  output logic [sxe_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  input  logic                                char_valid,
  output logic                                char_stall,
  input  sxe_pkg::char_word_t                 char_word,
  output logic                                res_valid,
  input  logic                                res_stall,
  output sxe_pkg::res_word_t                  res_word
);

  localparam int DW = sxe_pkg::DATA_W;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_RD1  = 5'b00010,
    ST_RD2  = 5'b00100,
    ST_EXEC = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t                state;
  logic [CW-1:0]         count;
  logic signed [DW-1:0]  last_answer;
  sxe_pkg::status_t      err;
  logic                  mode;
  sxe_pkg::op_t          op;
  logic                  last;
  logic signed [DW-1:0]  first;

  logic                  accept;
  logic                  in_digit;
  logic                  in_op;
  logic [32:0]           dig_wide;
  logic signed [DW-1:0]  dig_val;
  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [DW-1:0]         ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [DW-1:0]         ram_rdata;
  logic signed [DW-1:0]  opnd_left;
  logic signed [DW-1:0]  opnd_right;
  logic                  div_zero;
  sxe_pkg::alu_req_t     alu_req;
  logic                  alu_done;
  logic signed [DW-1:0]  alu_result;
  logic                  emit_go;
  logic                  cfg_wr;

  always_comb begin
    pready     = 1'b1;
    cfg_wr     = psel && penable && pwrite && pready;
    prdata     = (paddr[2] == sxe_pkg::REG_MODE) ? {{(DW-1){1'b0}}, mode} : '0;

    char_stall = state != ST_IDLE;
    accept     = char_valid && !char_stall;
    in_digit   = (char_word.char_code >= sxe_pkg::CH_ZERO) &&
                 (char_word.char_code <= sxe_pkg::CH_NINE);
    in_op      = sxe_pkg::is_op_char(char_word.char_code);
    dig_wide   = 33'(char_word.char_code[3:0]) << FRAC_BITS;
    dig_val    = (dig_wide > 33'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : dig_wide[DW-1:0];

    opnd_left  = mode ? first : ram_rdata;
    opnd_right = mode ? ram_rdata : first;
    div_zero   = (op == sxe_pkg::OP_DIV) && (opnd_right == '0);

    alu_req.start = (state == ST_RD2) && !div_zero;
    alu_req.op    = op;

    ram_we    = 1'b0;
    ram_waddr = AW'(count);
    ram_wdata = dig_val;
    if (accept && err == sxe_pkg::STS_OK && in_digit && count < CW'(STACK_DEPTH)) begin
      ram_we = 1'b1;
    end
    if (state == ST_EXEC && alu_done) begin
      ram_we    = 1'b1;
      ram_wdata = alu_result;
    end
    ram_raddr = (state == ST_IDLE) ? AW'(count - CW'(1)) : AW'(count - CW'(2));

    emit_go = (state == ST_EMIT) && (!res_valid || !res_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      count       <= '0;
      last_answer <= '0;
      err         <= sxe_pkg::STS_OK;
      mode        <= 1'b0;
      res_valid   <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == sxe_pkg::REG_MODE) begin
        mode <= pwdata[0];
      end
      if (emit_go) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (err == sxe_pkg::STS_OK && in_digit) begin
              if (count >= CW'(STACK_DEPTH)) begin
                err <= sxe_pkg::STS_OVF;
              end else begin
                count <= count + 1'b1;
              end
            end
            if (err == sxe_pkg::STS_OK && in_op && count < CW'(2)) begin
              err <= sxe_pkg::STS_UNDER;
            end
            if (err == sxe_pkg::STS_OK && in_op && count >= CW'(2)) begin
              state <= ST_RD1;
            end else if (char_word.is_last) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_RD1: state <= ST_RD2;
        ST_RD2: begin
          count <= count - CW'(2);
          if (div_zero) begin
            err   <= sxe_pkg::STS_DIV0;
            state <= last ? ST_EMIT : ST_IDLE;
          end else begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (alu_done) begin
            count       <= count + 1'b1;
            last_answer <= alu_result;
            state       <= last ? ST_EMIT : ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (emit_go) begin
            count       <= '0;
            last_answer <= '0;
            err         <= sxe_pkg::STS_OK;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= sxe_pkg::op_decode(char_word.char_code);
      last <= char_word.is_last;
    end
    if (state == ST_RD1) begin
      first <= ram_rdata;
    end
    if (emit_go) begin
      res_word.value  <= (err == sxe_pkg::STS_OK) ? last_answer : '0;
      res_word.status <= err;
    end
  end

  sxe_ram #(
    .WIDTH (DW),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  sxe_alu #(
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .clk    (clk),
    .rst    (rst),
    .req    (alu_req),
    .left   (opnd_left),
    .right  (opnd_right),
    .done   (alu_done),
    .result (alu_result)
  );

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_res_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state == ST_EMIT))
    else $error("result raised outside emit");

  a_alu_done_exec: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> state == ST_EXEC)
    else $error("alu finished while sequencer not waiting");

  a_emit_clears: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> count == '0 && err == sxe_pkg::STS_OK && last_answer == '0)
    else $error("expression state not cleared after result");

  a_err_zero_value: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_word.status != sxe_pkg::STS_OK |-> res_word.value == '0)
    else $error("nonzero value with error status");

endmodule

>>> src/sxe_ram.sv
// sxe_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.

module sxe_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/sxe_alu.sv
// sxe_alu: fixed-point add/sub, multiply and bit-serial restoring divide.
// Depends on sxe_pkg.

module sxe_alu #(
  parameter int FRAC_BITS = sxe_pkg::FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  sxe_pkg::alu_req_t                     req,
  input  logic signed [sxe_pkg::DATA_W-1:0]     left,
  input  logic signed [sxe_pkg::DATA_W-1:0]     right,
  output logic                                  done,
  output logic signed [sxe_pkg::DATA_W-1:0]     result
);

  localparam int DW = sxe_pkg::DATA_W;
  localparam int QW = DW + FRAC_BITS;
  localparam int NW = $clog2(QW + 1);

  typedef enum logic [3:0] {
    A_IDLE = 4'b0001,
    A_MUL  = 4'b0010,
    A_DIV  = 4'b0100,
    A_DFIN = 4'b1000
  } astate_t;

  astate_t            astate;
  logic signed [63:0] prod;
  logic               neg;
  logic [DW-1:0]      divisor;
  logic [QW-1:0]      quo;
  logic [DW-1:0]      rem;
  logic [NW-1:0]      steps;

  logic signed [63:0] sum;
  logic signed [63:0] diff;
  logic signed [63:0] shifted;
  logic [DW-1:0]      na;
  logic [DW-1:0]      nb;
  logic [DW:0]        rem_sh;
  logic [DW:0]        rem_sub;
  logic               fits;
  logic [63:0]        qwide;

  always_comb begin
    sum     = 64'(left) + 64'(right);
    diff    = 64'(left) - 64'(right);
    shifted = prod >>> FRAC_BITS;
    na      = left[DW-1]  ? (~left + 1'b1)  : left;
    nb      = right[DW-1] ? (~right + 1'b1) : right;
    rem_sh  = {rem, quo[QW-1]};
    rem_sub = rem_sh - {1'b0, divisor};
    fits    = rem_sh >= {1'b0, divisor};
    qwide   = 64'(quo);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      astate <= A_IDLE;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      case (astate)
        A_IDLE: begin
          if (req.start) begin
            case (req.op)
              sxe_pkg::OP_ADD: begin
                result <= sxe_pkg::sat32(sum);
                done   <= 1'b1;
              end
              sxe_pkg::OP_SUB: begin
                result <= sxe_pkg::sat32(diff);
                done   <= 1'b1;
              end
              sxe_pkg::OP_MUL: begin
                prod   <= left * right;
                astate <= A_MUL;
              end
              default: begin
                neg     <= left[DW-1] ^ right[DW-1];
                divisor <= nb;
                quo     <= QW'(na) << FRAC_BITS;
                rem     <= '0;
                steps   <= NW'(QW);
                astate  <= A_DIV;
              end
            endcase
          end
        end
        A_MUL: begin
          result <= sxe_pkg::sat32(shifted);
          done   <= 1'b1;
          astate <= A_IDLE;
        end
        A_DIV: begin
          rem   <= fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
          quo   <= {quo[QW-2:0], fits};
          steps <= steps - 1'b1;
          if (steps == NW'(1)) begin
            astate <= A_DFIN;
          end
        end
        A_DFIN: begin
          if (neg) begin
            result <= (qwide > 64'h8000_0000) ? 32'sh8000_0000 : DW'(-qwide);
          end else begin
            result <= (qwide > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : DW'(qwide);
          end
          done   <= 1'b1;
          astate <= A_IDLE;
        end
        default: astate <= A_IDLE;
      endcase
    end
  end

endmodule

>>> tb/sv/sxe_checker.sv
// sxe_checker: watches the char, result and register ports of the stack expression
// evaluator, predicts every result word in fixed point and compares it in order.
// Depends on sxe_pkg; instantiated by testbench beside the block.

module sxe_checker #(
  parameter int                          STACK_DEPTH = sxe_pkg::STACK_DEPTH_DEF,
  parameter int                          FRAC_BITS   = sxe_pkg::FRAC_BITS_DEF,
  parameter logic [sxe_pkg::PADDR_W-1:0] MODE_ADDR   = '0
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [sxe_pkg::PADDR_W-1:0] paddr,
  input  logic [sxe_pkg::DATA_W-1:0]  pwdata,
  input  logic [sxe_pkg::DATA_W-1:0]  prdata,
  input  logic                        char_valid,
  input  logic                        char_stall,
  input  sxe_pkg::char_word_t         char_word,
  input  logic                        res_valid,
  input  logic                        res_stall,
  input  sxe_pkg::res_word_t          res_word,
  output int                          fail_count,
  output int                          pending
);

  logic signed [31:0]  operands [STACK_DEPTH];
  int unsigned         depth = 0;
  logic signed [31:0]  answer = '0;
  sxe_pkg::status_t    err = sxe_pkg::STS_OK;
  logic                prefix_mode = 1'b0;
  sxe_pkg::res_word_t  answer_q [$];
  int                  errors = 0;

  function automatic logic signed [31:0] clamp32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7FFF_FFFF;
    if (x < -64'sd2147483648) return 32'sh8000_0000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] fixed_mul(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [63:0] wa, wb, p;
    wa = a;
    wb = b;
    p = wa * wb;
    return clamp32(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] fixed_div(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
    logic signed [63:0] wa, wb;
    logic [63:0]        na, nb, q;
    logic               neg;
    wa = a;
    wb = b;
    neg = (wa < 0) != (wb < 0);
    na = (wa < 0) ? -wa : wa;
    nb = (wb < 0) ? -wb : wb;
    q = (na << FRAC_BITS) / nb;
    if (neg) begin
      if (q > 64'h8000_0000) q = 64'h8000_0000;
      return clamp32(-$signed(q));
    end
    if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
    return q[31:0];
  endfunction

  task automatic eval_char(input logic [7:0] c);
    logic signed [31:0] first, second, lhs, rhs, r;
    logic signed [63:0] wl, wr;
    if (c >= sxe_pkg::CH_ZERO && c <= sxe_pkg::CH_NINE) begin
      if (depth >= STACK_DEPTH) begin
        err = sxe_pkg::STS_OVF;
      end else begin
        operands[depth] = clamp32(64'(c - sxe_pkg::CH_ZERO) << FRAC_BITS);
        depth++;
      end
    end else if (c == sxe_pkg::CH_PLUS || c == sxe_pkg::CH_MINUS ||
                 c == sxe_pkg::CH_STAR || c == sxe_pkg::CH_SLASH) begin
      if (depth < 2) begin
        err = sxe_pkg::STS_UNDER;
      end else begin
        first = operands[depth-1];
        second = operands[depth-2];
        depth -= 2;
        lhs = prefix_mode ? first : second;
        rhs = prefix_mode ? second : first;
        wl = lhs;
        wr = rhs;
        r = '0;
        case (c)
          sxe_pkg::CH_PLUS:  r = clamp32(wl + wr);
          sxe_pkg::CH_MINUS: r = clamp32(wl - wr);
          sxe_pkg::CH_STAR:  r = fixed_mul(lhs, rhs);
          default: begin
            if (rhs == 0) err = sxe_pkg::STS_DIV0;
            else r = fixed_div(lhs, rhs);
          end
        endcase
        if (err == sxe_pkg::STS_OK) begin
          answer = r;
          operands[depth] = r;
          depth++;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    sxe_pkg::res_word_t want;
    if (rst) begin
      depth = 0;
      answer = '0;
      err = sxe_pkg::STS_OK;
      prefix_mode = 1'b0;
      answer_q.delete();
    end else begin
      if (res_valid && !res_stall) begin
        if (answer_q.size() == 0) begin
          if (errors < 10)
            $display("unexpected result word: value %h status %0d",
                     res_word.value, res_word.status);
          errors++;
        end else begin
          want = answer_q.pop_front();
          if (res_word.value !== want.value || res_word.status !== want.status) begin
            if (errors < 10)
              $display("result mismatch: expected value %h status %0d, got value %h status %0d",
                       want.value, want.status, res_word.value, res_word.status);
            errors++;
          end
        end
      end
      if (char_valid && !char_stall) begin
        if (err == sxe_pkg::STS_OK) eval_char(char_word.char_code);
        if (char_word.is_last) begin
          want.value = (err == sxe_pkg::STS_OK) ? answer : '0;
          want.status = err;
          answer_q.push_back(want);
          depth = 0;
          answer = '0;
          err = sxe_pkg::STS_OK;
        end
      end
      if (psel && penable && pready && paddr == MODE_ADDR) begin
        if (pwrite) begin
          prefix_mode = pwdata[0];
        end else if (prdata !== {{(sxe_pkg::DATA_W-1){1'b0}}, prefix_mode}) begin
          if (errors < 10)
            $display("mode readback mismatch: expected %0d, got %h", prefix_mode, prdata);
          errors++;
        end
      end
    end
    fail_count <= errors;
    pending <= answer_q.size();
  end

endmodule

>>> tb/sv/testbench.sv
// testbench: top of the stack expression evaluator bench; drives directed and random
// expressions in both notations under several idle/stall mixes and gives the verdict.
// Depends on sxe_pkg, stack_expression_evaluator and sxe_checker.

module testbench;

  localparam logic [sxe_pkg::PADDR_W-1:0] MODE_ADDR = {sxe_pkg::REG_MODE, 2'b00};
  localparam int IDLE_LIMIT   = 5000;
  localparam int DRAIN_CYCLES = 64;
  localparam int ITEM_GOAL    = 1650;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [sxe_pkg::PADDR_W-1:0] paddr = '0;
  logic [sxe_pkg::DATA_W-1:0]  pwdata = '0;
  logic [sxe_pkg::DATA_W-1:0]  prdata;
  logic                        pready;
  logic                        char_valid = 1'b0;
  logic                        char_stall;
  sxe_pkg::char_word_t         char_word = '0;
  logic                        res_valid;
  logic                        res_stall = 1'b0;
  sxe_pkg::res_word_t          res_word;

  int fail_count;
  int pending;
  int send_idle = 0;
  int recv_stall = 0;
  int items = 0;
  int quiet = 0;

  stack_expression_evaluator dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .char_valid(char_valid), .char_stall(char_stall), .char_word(char_word),
    .res_valid(res_valid), .res_stall(res_stall), .res_word(res_word)
  );

  sxe_checker #(.MODE_ADDR(MODE_ADDR)) u_checker (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata),
    .char_valid(char_valid), .char_stall(char_stall), .char_word(char_word),
    .res_valid(res_valid), .res_stall(res_stall), .res_word(res_word),
    .fail_count(fail_count), .pending(pending)
  );

  always #10 clk = ~clk;

  always @(negedge clk) begin
    res_stall <= !rst && ($urandom_range(99) < recv_stall);
  end

  always @(posedge clk) begin
    if ((char_valid && !char_stall) || (res_valid && !res_stall) ||
        (psel && penable && pready)) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic apb_access(input logic wr, input logic [sxe_pkg::DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= MODE_ADDR;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_notation(input logic prefix);
    apb_access(1'b1, {{(sxe_pkg::DATA_W-1){1'b0}}, prefix});
    apb_access(1'b0, '0);
  endtask

  task automatic send_word(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle) begin
      char_valid <= 1'b0;
      @(negedge clk);
    end
    char_valid <= 1'b1;
    char_word.char_code <= c;
    char_word.is_last <= last;
    do @(posedge clk); while (char_stall);
    items++;
    @(negedge clk);
  endtask

  task automatic send_expr(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], i == s.len() - 1);
  endtask

  task automatic drain();
    char_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_op();
    case ($urandom_range(3))
      0: return sxe_pkg::CH_PLUS;
      1: return sxe_pkg::CH_MINUS;
      2: return sxe_pkg::CH_STAR;
      default: return sxe_pkg::CH_SLASH;
    endcase
  endfunction

  function automatic logic [7:0] pick_digit(input int lo, input int hi);
    return sxe_pkg::CH_ZERO + 8'($urandom_range(hi, lo));
  endfunction

  task automatic send_random_expr();
    logic [7:0] seq [$];
    int kind, operands, pushed, depth, n;
    kind = $urandom_range(99);
    if (kind < 70) begin
      // well-formed tree with occasional junk bytes
      operands = ($urandom_range(9) == 0) ? $urandom_range(16, 8) : $urandom_range(5, 1);
      pushed = 0;
      depth = 0;
      while (pushed < operands || depth > 1) begin
        if (pushed < operands && (depth < 2 || $urandom_range(1) == 0)) begin
          seq.push_back(pick_digit(0, 9));
          pushed++;
          depth++;
        end else begin
          seq.push_back(pick_op());
          depth--;
        end
        if ($urandom_range(19) == 0) seq.push_back(8'($urandom));
      end
    end else if (kind < 80) begin
      // chains that push values toward saturation or into fractions
      seq.push_back(pick_digit(1, 9));
      n = $urandom_range(7, 2);
      repeat (n) begin
        seq.push_back(pick_digit(1, 9));
        case ($urandom_range(4))
          0, 1: seq.push_back(sxe_pkg::CH_STAR);
          2: seq.push_back(sxe_pkg::CH_SLASH);
          3: seq.push_back(sxe_pkg::CH_MINUS);
          default: seq.push_back(sxe_pkg::CH_PLUS);
        endcase
      end
    end else if (kind < 88) begin
      n = $urandom_range(36, 30);
      repeat (n) seq.push_back(pick_digit(0, 9));
      repeat ($urandom_range(3)) seq.push_back(pick_op());
    end else if (kind < 95) begin
      n = $urandom_range(8, 1);
      repeat (n) seq.push_back(($urandom_range(2) == 0) ? pick_digit(0, 9) : pick_op());
    end else begin
      n = $urandom_range(6, 1);
      repeat (n) seq.push_back(8'($urandom));
    end
    for (int i = 0; i < seq.size(); i++) send_word(seq[i], i == seq.size() - 1);
  endtask

  initial begin
    int goal;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    set_notation(1'b0);
    send_expr("34+");
    send_word("8", 1'b0);
    send_word(8'h00, 1'b0);
    send_word("2", 1'b0);
    send_word(8'hFF, 1'b0);
    send_word("/", 1'b1);
    send_expr("50/");
    send_expr("+");
    send_expr("a");
    send_expr("12+3");
    send_expr("09-7*");
    drain();
    set_notation(1'b1);
    send_expr("24-");
    send_expr("30/");
    send_expr("03/");
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      set_notation(ph[0]);
      case (ph / 2)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 87; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 87; end
        default: begin send_idle = 8; recv_stall = 8; end
      endcase
      goal = items + (ITEM_GOAL - items) / (8 - ph);
      while (items < goal) send_random_expr();
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
